// ===== rtl/core/drpe_pkg.sv =====
// Package for the dimmer remote pulse encoder.
// Holds the shared types, error codes, register indexes and frame constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drpe_pkg;

	localparam int unsigned ID_W      = 26;
	localparam int unsigned FIELD_W   = 5;
	localparam int unsigned BASE_W    = 10;
	localparam int unsigned MULT_W    = 6;
	localparam int unsigned PULSE_W   = 16;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned FRAME_W   = 36;
	localparam int unsigned IDX_W     = 6;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_ID    = 2'd1;
	localparam logic [1:0] ERR_UNIT  = 2'd2;
	localparam logic [1:0] ERR_LEVEL = 2'd3;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_HEADER = 2'd1;
	localparam logic [1:0] REG_LONG   = 2'd2;
	localparam logic [1:0] REG_FOOTER = 2'd3;

	localparam logic [BASE_W-1:0] BASE_RST   = 10'd275;
	localparam logic [MULT_W-1:0] HEADER_RST = 6'd10;
	localparam logic [MULT_W-1:0] LONG_RST   = 6'd5;
	localparam logic [MULT_W-1:0] FOOTER_RST = 6'd38;

	localparam logic [IDX_W-1:0] IDX_START = 6'd0;
	localparam logic [IDX_W-1:0] IDX_DIM   = 6'd28;
	localparam logic [IDX_W-1:0] IDX_END   = 6'd37;

	localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
	localparam logic [CNT_W-1:0] CNT_PAIR = 3'd2;
	localparam logic [CNT_W-1:0] CNT_QUAD = 3'd4;

	typedef struct packed {
		logic [1:0]         err;
		logic [FRAME_W-1:0] bits;
	} cmd_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [MULT_W-1:0] header;
		logic [MULT_W-1:0] long_mult;
		logic [MULT_W-1:0] footer;
	} cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] a;
		logic [PULSE_W-1:0] b;
		logic [PULSE_W-1:0] c;
		logic [PULSE_W-1:0] d;
		logic [CNT_W-1:0]   cnt;
		logic [1:0]         err;
		logic               last;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/core/drpe_front.sv =====
// Front end: accepts commands, checks them and packs the frame bits.
// Holds a two-entry queue toward the back end. Uses drpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drpe_front import drpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [ID_W-1:0]    device_id,
	input  wire logic               all_units,
	input  wire logic [FIELD_W-1:0] unit_number,
	input  wire logic [FIELD_W-1:0] dim_level,
	output logic                    cmd_valid,
	input  wire logic               cmd_pop,
	output cmd_t                    cmd
);

	cmd_t       entry_q [2];
	cmd_t       chk;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	always_comb begin
		chk.bits = {device_id, all_units, 1'b0, unit_number[3:0], dim_level[3:0]};
		if (device_id == '0) begin
			chk.err = ERR_ID;
		end else if (!all_units && unit_number[4]) begin
			chk.err = ERR_UNIT;
		end else if (dim_level[4]) begin
			chk.err = ERR_LEVEL;
		end else begin
			chk.err = ERR_OK;
		end
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= chk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/drpe_back.sv =====
// Back end: expands one checked command into pulse items, one per cycle
// while the result queue has room. Holds the symbol sequencer, the pulse
// products and a two-entry result queue. Uses drpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drpe_back import drpe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	input  wire cmd_t cmd,
	output logic      empty,
	input  wire logic pop,
	output item_t     item
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic               state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [1:0]         err_q;
	logic [FRAME_W-1:0] shift_q;
	logic [PULSE_W-1:0] long_q;
	logic [PULSE_W-1:0] header_q;
	logic [PULSE_W-1:0] footer_q;
	logic [PULSE_W-1:0] sp;
	item_t              gen_item;
	item_t              out_q [2];
	logic               owr_q;
	logic               ord_q;
	logic [1:0]         ocnt_q;
	logic               gen;
	logic               finish;
	logic               orear;

	assign sp = {{(PULSE_W-BASE_W){1'b0}}, cfg.base};

	always_ff @(posedge clk) begin
		long_q   <= PULSE_W'(cfg.long_mult * cfg.base);
		header_q <= PULSE_W'(cfg.header * cfg.base);
		footer_q <= PULSE_W'(cfg.footer * cfg.base);
	end

	assign gen     = (state_q == ST_RUN) && (ocnt_q != 2'd2);
	assign finish  = (err_q != ERR_OK) || (idx_q == IDX_END);
	assign cmd_pop = cmd_valid && ((state_q == ST_IDLE) || (gen && finish));

	always_comb begin
		gen_item = '0;
		if (err_q != ERR_OK) begin
			gen_item.err  = err_q;
			gen_item.cnt  = CNT_NONE;
			gen_item.last = 1'b1;
		end else if (idx_q == IDX_START) begin
			gen_item.a   = sp;
			gen_item.b   = header_q;
			gen_item.cnt = CNT_PAIR;
		end else if (idx_q == IDX_END) begin
			gen_item.a    = sp;
			gen_item.b    = footer_q;
			gen_item.cnt  = CNT_PAIR;
			gen_item.last = 1'b1;
		end else begin
			gen_item.a   = sp;
			gen_item.b   = sp;
			gen_item.c   = sp;
			gen_item.d   = sp;
			gen_item.cnt = CNT_QUAD;
			if (idx_q != IDX_DIM) begin
				if (shift_q[FRAME_W-1]) begin
					gen_item.b = long_q;
				end else begin
					gen_item.d = long_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			shift_q <= cmd.bits;
			err_q   <= cmd.err;
		end else if (gen && idx_q != IDX_START) begin
			shift_q <= {shift_q[FRAME_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= IDX_START;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						state_q <= ST_RUN;
						idx_q   <= IDX_START;
					end
				end
				ST_RUN: begin
					if (gen) begin
						if (finish) begin
							idx_q <= IDX_START;
							if (!cmd_pop) begin
								state_q <= ST_IDLE;
							end
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign item  = out_q[ord_q];
	assign orear = pop && !empty;

	always_ff @(posedge clk) begin
		if (gen) begin
			out_q[owr_q] <= gen_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (gen) begin
				owr_q <= !owr_q;
			end
			if (orear) begin
				ord_q <= !ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, gen} - {1'b0, orear};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dimmer_remote_pulse_encoder.sv =====
// Dimmer remote pulse encoder: top level with the configuration registers.
// Instantiates drpe_front and drpe_back. Uses drpe_pkg.
//
// Usage:
//   Commands enter through push/full; a transaction moves when push is high
//   and full is low. Pulse items leave through empty/pop; the oldest item is
//   on the result ports while empty is low and leaves when pop is high.
//   A good command yields 38 items (start pair, 36 symbols, footer pair with
//   last_item set); a rejected command yields one error item.
//   A command's first item passes the command queue and the sequencer. The
//   sequencer in the back end makes one item per cycle while the result queue
//   has room; a two-entry command queue lets up to two commands wait while a
//   frame is being sent. When the receiver stalls, the two-entry result queue
//   fills, the sequencer holds, and then the command queue fills and
//   full rises; nothing is lost. Registers must be written through
//   cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//   Reset empties both queues and loads the register defaults
//   (275, 10, 5, 38); the block is ready the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module dimmer_remote_pulse_encoder import drpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [ID_W-1:0]    device_id,
	input  wire logic               all_units,
	input  wire logic [FIELD_W-1:0] unit_number,
	input  wire logic [FIELD_W-1:0] dim_level,
	output logic                    empty,
	input  wire logic               pop,
	output logic [PULSE_W-1:0]      pulse_a,
	output logic [PULSE_W-1:0]      pulse_b,
	output logic [PULSE_W-1:0]      pulse_c,
	output logic [PULSE_W-1:0]      pulse_d,
	output logic [CNT_W-1:0]        pulse_count,
	output logic [1:0]              error_code,
	output logic                    last_item,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [BASE_W-1:0]  cfg_data
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_pop;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base      <= BASE_RST;
			cfg_q.header    <= HEADER_RST;
			cfg_q.long_mult <= LONG_RST;
			cfg_q.footer    <= FOOTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:   cfg_q.base      <= cfg_data;
				REG_HEADER: cfg_q.header    <= cfg_data[MULT_W-1:0];
				REG_LONG:   cfg_q.long_mult <= cfg_data[MULT_W-1:0];
				REG_FOOTER: cfg_q.footer    <= cfg_data[MULT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	drpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.device_id   (device_id),
		.all_units   (all_units),
		.unit_number (unit_number),
		.dim_level   (dim_level),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	drpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.item      (item)
	);

	assign pulse_a     = item.a;
	assign pulse_b     = item.b;
	assign pulse_c     = item.c;
	assign pulse_d     = item.d;
	assign pulse_count = item.cnt;
	assign error_code  = item.err;
	assign last_item   = item.last;

endmodule

`default_nettype wire

// ===== rtl/core/drpe_checker.sv =====
// Port-level checks for the dimmer remote pulse encoder, bound to the top.
// Depends on drpe_pkg and dimmer_remote_pulse_encoder.
`timescale 1ns / 1ps
`default_nettype none

module drpe_checker import drpe_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic [PULSE_W-1:0] pulse_a,
	input wire logic [PULSE_W-1:0] pulse_b,
	input wire logic [PULSE_W-1:0] pulse_c,
	input wire logic [PULSE_W-1:0] pulse_d,
	input wire logic [CNT_W-1:0]   pulse_count,
	input wire logic [1:0]         error_code,
	input wire logic               last_item
);

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pulse_count == CNT_NONE || pulse_count == CNT_PAIR ||
			pulse_count == CNT_QUAD))
		else $error("pulse_count out of range");

	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_code != ERR_OK) |->
			(pulse_count == CNT_NONE && last_item && pulse_a == '0 && pulse_b == '0))
		else $error("error item malformed");

	a_pair_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pulse_count == CNT_PAIR) |-> (pulse_c == '0 && pulse_d == '0))
		else $error("two-pulse item has nonzero tail");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pulse_a) && $stable(pulse_b) &&
			$stable(last_item) && $stable(pulse_count)))
		else $error("result changed while stalled");

endmodule

bind dimmer_remote_pulse_encoder drpe_checker u_drpe_checker (.*);

`default_nettype wire

// ===== bench/tb_dimmer_remote_pulse_encoder.sv =====
// Testbench for dimmer_remote_pulse_encoder: drives commands and register settings and
// checks every pulse item against a frame predictor kept inside the bench.
// Depends on drpe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_dimmer_remote_pulse_encoder;
	import drpe_pkg::*;

	localparam int unsigned NIBBLE_MAX  = 15;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned PHASES      = 5;
	localparam int unsigned PHASE_ITEMS = 28;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [ID_W-1:0]    device_id = '0;
	logic               all_units = 1'b0;
	logic [FIELD_W-1:0] unit_number = '0;
	logic [FIELD_W-1:0] dim_level = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [PULSE_W-1:0] pulse_a;
	logic [PULSE_W-1:0] pulse_b;
	logic [PULSE_W-1:0] pulse_c;
	logic [PULSE_W-1:0] pulse_d;
	logic [CNT_W-1:0]   pulse_count;
	logic [1:0]         error_code;
	logic               last_item;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [BASE_W-1:0]  cfg_data = '0;

	cfg_t               shadow_cfg = '{base: BASE_RST, header: HEADER_RST,
		long_mult: LONG_RST, footer: FOOTER_RST};
	logic [FRAME_W-1:0] last_frame = '0;
	item_t              pending_pulses[$];
	int unsigned        mismatch_count = 0;
	logic               no_idle = 1'b0;

	dimmer_remote_pulse_encoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.device_id   (device_id),
		.all_units   (all_units),
		.unit_number (unit_number),
		.dim_level   (dim_level),
		.empty       (empty),
		.pop         (pop),
		.pulse_a     (pulse_a),
		.pulse_b     (pulse_b),
		.pulse_c     (pulse_c),
		.pulse_d     (pulse_d),
		.pulse_count (pulse_count),
		.error_code  (error_code),
		.last_item   (last_item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic predict_frame(input logic [ID_W-1:0] id, input logic all,
			input logic [FIELD_W-1:0] unit, input logic [FIELD_W-1:0] level);
		logic [1:0]         err;
		logic [PULSE_W-1:0] sp;
		logic [PULSE_W-1:0] lp;
		logic [PULSE_W-1:0] hp;
		logic [PULSE_W-1:0] fp;
		logic               bit_val;
		err = ERR_OK;
		if (id == '0)
			err = ERR_ID;
		else if (!all && unit > NIBBLE_MAX)
			err = ERR_UNIT;
		else if (level > NIBBLE_MAX)
			err = ERR_LEVEL;
		if (err != ERR_OK) begin
			pending_pulses.push_back('{a: '0, b: '0, c: '0, d: '0, cnt: CNT_NONE,
				err: err, last: 1'b1});
		end else begin
			last_frame = {id, all, 1'b0, unit[3:0], level[3:0]};
			sp = shadow_cfg.base;
			lp = shadow_cfg.long_mult * sp;
			hp = shadow_cfg.header * sp;
			fp = shadow_cfg.footer * sp;
			pending_pulses.push_back('{a: sp, b: hp, c: '0, d: '0, cnt: CNT_PAIR,
				err: ERR_OK, last: 1'b0});
			for (int k = 1; k <= FRAME_W; k++) begin
				bit_val = last_frame[FRAME_W-k];
				if (k == IDX_DIM)
					pending_pulses.push_back('{a: sp, b: sp, c: sp, d: sp, cnt: CNT_QUAD,
						err: ERR_OK, last: 1'b0});
				else if (bit_val)
					pending_pulses.push_back('{a: sp, b: lp, c: sp, d: sp, cnt: CNT_QUAD,
						err: ERR_OK, last: 1'b0});
				else
					pending_pulses.push_back('{a: sp, b: sp, c: sp, d: lp, cnt: CNT_QUAD,
						err: ERR_OK, last: 1'b0});
			end
			pending_pulses.push_back('{a: sp, b: fp, c: '0, d: '0, cnt: CNT_PAIR,
				err: ERR_OK, last: 1'b1});
		end
	endtask

	task automatic send_command(input logic [ID_W-1:0] id, input logic all,
			input logic [FIELD_W-1:0] unit, input logic [FIELD_W-1:0] level);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		device_id   <= id;
		all_units   <= all;
		unit_number <= unit;
		dim_level   <= level;
		do @(posedge clk); while (full);
		predict_frame(id, all, unit, level);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_registers(input cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data  <= c.base;
		@(posedge clk);
		cfg_index <= REG_HEADER;
		cfg_data  <= {4'($urandom), c.header};
		@(posedge clk);
		cfg_index <= REG_LONG;
		cfg_data  <= {4'($urandom), c.long_mult};
		@(posedge clk);
		cfg_index <= REG_FOOTER;
		cfg_data  <= {4'($urandom), c.footer};
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_cfg = c;
	endtask

	task automatic send_random_command();
		logic [ID_W-1:0]    id;
		logic               all;
		logic [FIELD_W-1:0] unit;
		logic [FIELD_W-1:0] level;
		id    = ID_W'($urandom);
		all   = 1'($urandom);
		unit  = FIELD_W'($urandom);
		level = FIELD_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			if (id == '0)
				id = 1;
			unit[FIELD_W-1]  = 1'b0;
			level[FIELD_W-1] = 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			id = '0;
		end
		send_command(id, all, unit, level);
	endtask

	task automatic test_defaults_and_errors();
		send_command(26'd1, 1'b0, 5'd0, 5'd0);
		send_command('1, 1'b1, 5'd31, 5'd15);
		send_command(26'h2AAAAAA, 1'b0, 5'd15, 5'd15);
		send_command(26'h1555555, 1'b0, 5'd10, 5'd5);
		send_command('0, 1'b0, 5'd31, 5'd31);
		send_command(26'd5, 1'b0, 5'd16, 5'd0);
		send_command(26'd5, 1'b0, 5'd31, 5'd31);
		send_command(26'd5, 1'b0, 5'd3, 5'd16);
		send_command(26'd5, 1'b1, 5'd16, 5'd31);
		send_command(26'd7, 1'b1, 5'd16, 5'd0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		cfg_t settings[4];
		settings[0] = '{base: 10'd1023, header: 6'd63, long_mult: 6'd63, footer: 6'd63};
		settings[1] = '{base: 10'd1, header: 6'd1, long_mult: 6'd1, footer: 6'd1};
		settings[2] = '{base: 10'd0, header: 6'd0, long_mult: 6'd0, footer: 6'd0};
		settings[3] = '{base: 10'd1023, header: 6'd1, long_mult: 6'd63, footer: 6'd1};
		foreach (settings[i]) begin
			load_registers(settings[i]);
			send_command('1, 1'b0, 5'd15, 5'd0);
			send_command(26'h0F0F0F1, 1'b1, 5'd9, 5'd15);
			wait_idle();
		end
	endtask

	task automatic test_random_traffic();
		cfg_t c;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				c = '{base: BASE_RST, header: HEADER_RST, long_mult: LONG_RST,
					footer: FOOTER_RST};
			else
				c = '{base: BASE_W'($urandom_range(1, 1023)),
					header: MULT_W'($urandom_range(1, 63)),
					long_mult: MULT_W'($urandom_range(1, 63)),
					footer: MULT_W'($urandom_range(1, 63))};
			load_registers(c);
			no_idle = (p == 2);
			repeat (PHASE_ITEMS) send_random_command();
			wait_idle();
			no_idle = 1'b0;
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin : result_check
		item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_pulses.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected item a=%0d b=%0d c=%0d d=%0d cnt=%0d err=%0d last=%0d",
					pulse_a, pulse_b, pulse_c, pulse_d, pulse_count, error_code,
					last_item));
			end else begin
				want = pending_pulses.pop_front();
				check_field("pulse_a", pulse_a, want.a);
				check_field("pulse_b", pulse_b, want.b);
				check_field("pulse_c", pulse_c, want.c);
				check_field("pulse_d", pulse_d, want.d);
				check_field("pulse_count", pulse_count, want.cnt);
				check_field("error_code", error_code, want.err);
				check_field("last_item", last_item, want.last);
			end
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_and_errors();
		test_register_extremes();
		test_random_traffic();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/drpe_pkg.sv
rtl/core/drpe_front.sv
rtl/core/drpe_back.sv
rtl/core/dimmer_remote_pulse_encoder.sv
rtl/core/drpe_checker.sv
bench/tb_dimmer_remote_pulse_encoder.sv
